// File: hw/rtl/wavetable_oscillator_assert.svh
// Assertion macros for the port-level checker of the wavetable oscillator.
`ifndef WAVETABLE_OSCILLATOR_ASSERT_SVH
`define WAVETABLE_OSCILLATOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define WAVOSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define WAVOSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/wavosc_pkg.sv
// Types and constants shared by the wavetable oscillator modules.
package wavosc_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int PHASE_W     = 32;
    localparam int POS_W       = 14;
    localparam int LAST_W      = 6;
    localparam int FRAC_W      = 8;
    localparam int SFRAC_W     = 16;
    localparam int LOAD_WAVE_W = 6;
    localparam int LOAD_IDX_W  = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Command fields are sized for the largest table the design supports.
    localparam int CMD_WAVE_W  = 8;
    localparam int CMD_IDX_W   = 13;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [PHASE_W-1:0] PHASE_INC_RESET = 32'd42949673;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_INC = 3'd0,
        CFG_WAVE_POS  = 3'd1,
        CFG_LAST_WAVE = 3'd2,
        CFG_SMOOTH    = 3'd3,
        CFG_MORPH     = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op                      op;
        logic [CMD_WAVE_W-1:0]        wave0;
        logic [CMD_WAVE_W-1:0]        wave1;
        logic [CMD_IDX_W-1:0]         index0;
        logic [CMD_IDX_W-1:0]         index1;
        logic [FRAC_W-1:0]            wfrac;
        logic [SFRAC_W-1:0]           sfrac;
        logic signed [SAMPLE_W-1:0]   value;
    } t_cmd;

endpackage

// File: hw/rtl/wavosc_if.sv
// Handshake interfaces for the input and result channels of the oscillator.
interface wavosc_in_if;
    import wavosc_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [LOAD_WAVE_W-1:0]       load_wave;
    logic [LOAD_IDX_W-1:0]        load_index;
    logic signed [SAMPLE_W-1:0]   load_value;

    modport source (output valid, output mode, output load_wave, output load_index,
                    output load_value, input ready);
    modport sink   (input valid, input mode, input load_wave, input load_index,
                    input load_value, output ready);
endinterface

interface wavosc_out_if;
    import wavosc_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [SAMPLE_W-1:0]   sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// File: hw/rtl/wavosc_queue.sv
// Small command queue between the front and back halves of the oscillator.
module wavosc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wavosc_pkg::t_cmd  i_push_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output wavosc_pkg::t_cmd  o_head
);
    import wavosc_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// File: hw/rtl/wavosc_front.sv
// Front half: configuration registers, phase accumulator and command building.
module wavosc_front #(
    parameter int TABLE_LENGTH = 2048,
    parameter int TABLE_WAVES  = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wavosc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wavosc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    wavosc_in_if.sink                         i_in,
    output logic                              o_push,
    output wavosc_pkg::t_cmd                  o_push_cmd,
    input  logic                              i_q_full
);
    import wavosc_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_LENGTH);
    localparam int PROD_W = PHASE_W + IDX_W + 1;
    localparam logic [CMD_WAVE_W-1:0] MAX_WAVE = CMD_WAVE_W'(TABLE_WAVES - 1);

    // Configuration registers
    logic [PHASE_W-1:0]   r_phase_inc;
    logic [POS_W-1:0]     r_wave_pos;
    logic [LAST_W-1:0]    r_last_wave;
    logic                 r_smooth;
    logic                 r_morph;
    logic [PHASE_W-1:0]   r_phase;

    // Holding stage for one accepted transaction
    logic                       r_hold_valid;
    logic                       r_hold_mode;
    logic [LOAD_WAVE_W-1:0]     r_hold_wave;
    logic [LOAD_IDX_W-1:0]      r_hold_index;
    logic signed [SAMPLE_W-1:0] r_hold_value;
    logic [PHASE_W-1:0]         r_hold_phase;

    logic                       accept;
    logic                       in_range;
    logic                       drop;
    logic                       hold_done;

    logic [PROD_W-1:0]          prod;
    logic [IDX_W-1:0]           idx;
    logic [IDX_W:0]             idx_inc;
    logic [IDX_W-1:0]           nxt;
    logic [SFRAC_W-1:0]         sf;
    logic [CMD_WAVE_W-1:0]      last_ext;
    logic [CMD_WAVE_W-1:0]      lw;
    logic [CMD_WAVE_W-1:0]      wi;
    logic [FRAC_W-1:0]          wf;
    logic                       morph;
    t_cmd                       cmd;

    assign in_range  = (32'(r_hold_wave) < 32'(TABLE_WAVES)) &&
                       (32'(r_hold_index) < 32'(TABLE_LENGTH));
    assign drop      = (r_hold_mode == MODE_LOAD) && !in_range;
    assign hold_done = r_hold_valid && (drop || !i_q_full);
    assign i_in.ready = !r_hold_valid || hold_done;
    assign accept    = i_in.valid && i_in.ready;
    assign o_push    = r_hold_valid && !drop && !i_q_full;
    assign o_push_cmd = cmd;

    // Sample index and fraction from the phase, waveform select from position.
    always_comb begin
        prod    = PROD_W'(r_hold_phase) * PROD_W'(TABLE_LENGTH);
        idx     = prod[PHASE_W +: IDX_W];
        sf      = prod[PHASE_W-1 -: SFRAC_W];
        idx_inc = {1'b0, idx} + 1'b1;
        nxt     = (idx_inc >= (IDX_W+1)'(TABLE_LENGTH)) ? '0 : idx_inc[IDX_W-1:0];

        last_ext = CMD_WAVE_W'(r_last_wave);
        lw       = (last_ext > MAX_WAVE) ? MAX_WAVE : last_ext;
        if ((CMD_WAVE_W+FRAC_W)'(r_wave_pos) > {lw, {FRAC_W{1'b0}}}) begin
            wi = lw;
            wf = '0;
        end else begin
            wi = CMD_WAVE_W'(r_wave_pos[POS_W-1:FRAC_W]);
            wf = r_wave_pos[FRAC_W-1:0];
        end
        morph = r_morph && (wi < lw);

        cmd = '0;
        if (r_hold_mode == MODE_TICK) begin
            cmd.op     = OP_TICK;
            cmd.wave0  = wi;
            cmd.wave1  = morph ? (wi + 1'b1) : wi;
            cmd.index0 = CMD_IDX_W'(idx);
            cmd.index1 = r_smooth ? CMD_IDX_W'(nxt) : CMD_IDX_W'(idx);
            cmd.wfrac  = wf;
            cmd.sfrac  = sf;
        end else begin
            cmd.op     = OP_WRITE;
            cmd.wave0  = CMD_WAVE_W'(r_hold_wave);
            cmd.index0 = CMD_IDX_W'(r_hold_index);
            cmd.value  = r_hold_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc  <= PHASE_INC_RESET;
            r_wave_pos   <= '0;
            r_last_wave  <= '0;
            r_smooth     <= 1'b0;
            r_morph      <= 1'b0;
            r_phase      <= '0;
            r_hold_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PHASE_INC: r_phase_inc <= i_cfg_data[PHASE_W-1:0];
                    CFG_WAVE_POS:  r_wave_pos  <= i_cfg_data[POS_W-1:0];
                    CFG_LAST_WAVE: r_last_wave <= i_cfg_data[LAST_W-1:0];
                    CFG_SMOOTH:    r_smooth    <= i_cfg_data[0];
                    CFG_MORPH:     r_morph     <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_hold_valid <= 1'b1;
                if (i_in.mode == MODE_TICK) begin
                    r_phase <= r_phase + r_phase_inc;
                end
            end else if (hold_done) begin
                r_hold_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hold_mode  <= i_in.mode;
            r_hold_wave  <= i_in.load_wave;
            r_hold_index <= i_in.load_index;
            r_hold_value <= i_in.load_value;
            r_hold_phase <= r_phase;
        end
    end

endmodule

// File: hw/rtl/wavosc_back.sv
// Back half: wave table memory, read sequencer and shared blend unit.
module wavosc_back #(
    parameter int TABLE_LENGTH = 2048,
    parameter int TABLE_WAVES  = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  wavosc_pkg::t_cmd  i_q_head,
    output logic              o_pop,
    wavosc_out_if.source      o_out
);
    import wavosc_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_LENGTH);
    localparam int WAVE_W = (TABLE_WAVES > 1) ? $clog2(TABLE_WAVES) : 1;
    localparam int DEPTH  = TABLE_WAVES * TABLE_LENGTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = SAMPLE_W + SFRAC_W + 2;
    localparam logic signed [PROD_W-1:0] RND_WAVE   = PROD_W'(2 ** (FRAC_W - 1));
    localparam logic signed [PROD_W-1:0] RND_SAMPLE = PROD_W'(2 ** (SFRAC_W - 1));

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_RD_D,
        S_MUL_CD,
        S_ADD_CD,
        S_MUL_S,
        S_DONE
    } t_state;

    function automatic logic [ADDR_W-1:0] table_addr(input logic [CMD_WAVE_W-1:0] w,
                                                     input logic [CMD_IDX_W-1:0] i);
        return ADDR_W'(w[WAVE_W-1:0]) * ADDR_W'(TABLE_LENGTH) + ADDR_W'(i[IDX_W-1:0]);
    endfunction

    logic signed [SAMPLE_W-1:0] r_table [DEPTH];

    t_state                     r_state;
    t_cmd                       r_cmd;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;

    logic signed [SAMPLE_W-1:0] r_rdata;
    logic signed [SAMPLE_W-1:0] r_wa;
    logic signed [SAMPLE_W-1:0] r_wc;
    logic signed [SAMPLE_W-1:0] r_a1;
    logic signed [SAMPLE_W-1:0] r_a2;
    logic signed [SAMPLE_W-1:0] r_base;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_shift16;

    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [ADDR_W-1:0]          mem_raddr;
    logic signed [SAMPLE_W-1:0] op_a;
    logic signed [SAMPLE_W-1:0] op_b;
    logic [SFRAC_W-1:0]         op_f;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [SFRAC_W:0]    factor;
    logic signed [PROD_W-1:0]   n_prod;
    logic signed [PROD_W-1:0]   shifted;
    logic [PROD_W-1:0]          sum;
    logic signed [SAMPLE_W-1:0] blend_res;
    logic                       out_free;

    assign o_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign mem_we    = o_pop && (i_q_head.op == OP_WRITE);
    assign mem_waddr = table_addr(i_q_head.wave0, i_q_head.index0);
    assign out_free  = !r_out_valid || o_out.ready;

    assign o_out.valid  = r_out_valid;
    assign o_out.sample = r_out_sample;

    // Read order: A and B share the sample index, C and D use its neighbour.
    always_comb begin
        unique case (r_state)
            S_RD_B:  mem_raddr = table_addr(r_cmd.wave1, r_cmd.index0);
            S_RD_C:  mem_raddr = table_addr(r_cmd.wave0, r_cmd.index1);
            S_RD_D:  mem_raddr = table_addr(r_cmd.wave1, r_cmd.index1);
            default: mem_raddr = table_addr(r_cmd.wave0, r_cmd.index0);
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_MUL_CD: begin
                op_a = r_wc;
                op_b = r_rdata;
                op_f = SFRAC_W'(r_cmd.wfrac);
            end
            S_MUL_S: begin
                op_a = r_a1;
                op_b = r_a2;
                op_f = r_cmd.sfrac;
            end
            default: begin
                op_a = r_wa;
                op_b = r_rdata;
                op_f = SFRAC_W'(r_cmd.wfrac);
            end
        endcase
        diff      = (SAMPLE_W+1)'(op_b) - (SAMPLE_W+1)'(op_a);
        factor    = {1'b0, op_f};
        n_prod    = PROD_W'(diff) * PROD_W'(factor)
                  + ((r_state == S_MUL_S) ? RND_SAMPLE : RND_WAVE);
        shifted   = r_shift16 ? (r_prod >>> SFRAC_W) : (r_prod >>> FRAC_W);
        sum       = PROD_W'(r_base) + shifted;
        blend_res = sum[SAMPLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= i_q_head.value;
        end
        r_rdata <= r_table[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        // The final product is held while the finished sample waits for room.
        if (r_state != S_DONE) begin
            r_prod    <= n_prod;
            r_shift16 <= (r_state == S_MUL_S);
        end
        unique case (r_state)
            S_RD_B:   r_wa <= r_rdata;
            S_RD_C:   r_base <= r_wa;
            S_RD_D: begin
                r_wc <= r_rdata;
                r_a1 <= blend_res;
            end
            S_MUL_CD: r_base <= r_wc;
            S_ADD_CD: r_a2 <= blend_res;
            S_MUL_S:  r_base <= r_a1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_sample <= blend_res;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && (i_q_head.op == OP_TICK)) begin
                        r_cmd   <= i_q_head;
                        r_state <= S_RD_A;
                    end
                end
                S_RD_A:   r_state <= S_RD_B;
                S_RD_B:   r_state <= S_RD_C;
                S_RD_C:   r_state <= S_RD_D;
                S_RD_D:   r_state <= S_MUL_CD;
                S_MUL_CD: r_state <= S_ADD_CD;
                S_ADD_CD: r_state <= S_MUL_S;
                S_MUL_S:  r_state <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: hw/rtl/wavetable_oscillator.sv
// A tick needs four reads through the single table port and three passes through the
// shared blend multiplier; the back half pops no new command until the tick's sample
// is in the output register, while a load leaves the back half free for the next one.
// Reset is synchronous and active low: it clears the phase, the queue and the
// handshakes and restores the register defaults; the wave table is not cleared
// and holds undefined words until loaded, so no clearing pass follows reset.
module wavetable_oscillator #(
    parameter int TABLE_LENGTH = 2048,
    parameter int TABLE_WAVES  = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wavosc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wavosc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    wavosc_in_if.sink                         i_in,
    wavosc_out_if.source                      o_out
);
    import wavosc_pkg::*;

    // The front half takes each input transaction into a holding register, works
    // out the table addresses and fractions of a tick from the phase and the
    // configuration, and advances the phase. Loads aimed outside the table are
    // dropped there and never reach the queue.
    logic q_push;
    t_cmd q_push_cmd;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd q_head;

    wavosc_front #(
        .TABLE_LENGTH (TABLE_LENGTH),
        .TABLE_WAVES  (TABLE_WAVES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_push     (q_push),
        .o_push_cmd (q_push_cmd),
        .i_q_full   (q_full)
    );

    // A four-entry queue lets loads and ticks keep arriving while the back half
    // is busy with the reads and blends of an earlier tick.
    wavosc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_empty    (q_empty),
        .o_head     (q_head)
    );

    // The back half owns the table. A load is written in the cycle it leaves the
    // queue. A tick reads four words (the two waveforms at the sample index and
    // at its neighbour); where morphing or smoothing is off the same word is read
    // twice, so that the corresponding blend reduces to that word. The result
    // waits in an output register, which lets the next command start.
    wavosc_back #(
        .TABLE_LENGTH (TABLE_LENGTH),
        .TABLE_WAVES  (TABLE_WAVES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

// File: hw/rtl/wavosc_checker.sv
// Port-level checker for the wavetable oscillator and its bind statement.
`include "wavetable_oscillator_assert.svh"

module wavosc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_in_mode,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [wavosc_pkg::SAMPLE_W-1:0]   i_out_sample
);
    import wavosc_pkg::*;

    // Ticks accepted whose samples have not yet been taken.
    logic [3:0] r_pend;
    logic [3:0] n_pend;
    logic       tick_acc;
    logic       out_acc;

    assign tick_acc = i_in_valid && i_in_ready && (i_in_mode == MODE_TICK);
    assign out_acc  = i_out_valid && i_out_ready;

    always_comb begin
        n_pend = r_pend;
        if (tick_acc && !out_acc) begin
            n_pend = r_pend + 1'b1;
        end else if (out_acc && !tick_acc) begin
            n_pend = r_pend - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    `WAVOSC_ASSERT_NOW(a_out_empty_after_reset, i_clk, i_rst_n, $rose(i_rst_n), !i_out_valid, "result offered straight after reset")
    `WAVOSC_ASSERT_NOW(a_ready_after_reset, i_clk, i_rst_n, $rose(i_rst_n), i_in_ready, "input not ready after reset")
    `WAVOSC_ASSERT_NOW(a_result_has_tick, i_clk, i_rst_n, i_out_valid, r_pend != 4'd0, "result without an outstanding tick")
    `WAVOSC_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_sample), "stalled result changed")

endmodule

bind wavetable_oscillator wavosc_checker u_wavosc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_mode    (i_in.mode),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample)
);
